### hw/rtl/rv32x_pkg.sv
// ----------------------------------------------------------------------------
// rv32x_pkg
// Shared types, codes and the instruction decoder for the rv32i subset
// execute block.
// ----------------------------------------------------------------------------
package rv32x_pkg;

	// default data memory size in bytes
	localparam int unsigned MEM_BYTES_DEF = 16384;

	// program counter after reset
	localparam logic [31:0] START_PC_RST = 32'h8000_0000;

	// the only accepted ebreak encoding
	localparam logic [31:0] EBREAK_WORD = 32'h0010_0073;

	// register a0
	localparam logic [4:0] REG_A0 = 5'd10;

	// result status codes
	typedef enum logic [1:0] {
		ST_EXEC    = 2'd0,
		ST_EBREAK  = 2'd1,
		ST_INVALID = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// decoded operations
	typedef enum logic [3:0] {
		OP_AUIPC   = 4'd0,
		OP_LBU     = 4'd1,
		OP_SB      = 4'd2,
		OP_ADDI    = 4'd3,
		OP_JAL     = 4'd4,
		OP_JALR    = 4'd5,
		OP_SW      = 4'd6,
		OP_EBREAK  = 4'd7,
		OP_INVALID = 4'd8
	} op_t;

	// register file write port
	typedef struct packed {
		logic        en;
		logic [4:0]  idx;
		logic [31:0] data;
	} rf_wr_t;

	// data memory request: we bit k enables byte k of the word at addr
	typedef struct packed {
		logic        rd_en;
		logic [3:0]  we;
		logic [31:0] addr;
		logic [31:0] wdata;
	} dm_req_t;

	// instruction decoder
	function automatic op_t decode_op(input logic [31:0] instr);
		op_t op;
		op = OP_INVALID;
		unique casez (instr)
			32'b???????_?????_?????_???_?????_0010111: op = OP_AUIPC;
			32'b???????_?????_?????_100_?????_0000011: op = OP_LBU;
			32'b???????_?????_?????_000_?????_0100011: op = OP_SB;
			32'b???????_?????_?????_000_?????_0010011: op = OP_ADDI;
			32'b???????_?????_?????_???_?????_1101111: op = OP_JAL;
			32'b???????_?????_?????_000_?????_1100111: op = OP_JALR;
			32'b???????_?????_?????_010_?????_0100011: op = OP_SW;
			32'b0000000_00001_00000_000_00000_1110011: op = OP_EBREAK;
			default:                                   op = OP_INVALID;
		endcase
		return op;
	endfunction

endpackage

### hw/rtl/rv32i_subset_execute.sv
// ----------------------------------------------------------------------------
// rv32i_subset_execute
// Executes one rv32i subset instruction per word against a register file,
// a program counter and a byte-addressed data memory.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   instruction
//   out      output     out_valid / out_stall status, executed_pc, next_pc,
//                                             dest_write, dest_index,
//                                             dest_value, halt_code
//   cfg      input      cfg_valid / cfg_ready start_pc
//
// Three stages: register read, execute with data memory access, output.
// One word per cycle sustained while out_stall is low; register results
// are forwarded from the data memory read and from the last write back
// into the execute stage. After reset the data memory clears its
// MEM_BYTES/4 rows (4096 by default), one row of four bytes per cycle,
// with in_stall held high.
// out_stall holds the output register and backs up the pipeline.
// ----------------------------------------------------------------------------
module rv32i_subset_execute #(
	parameter int unsigned MEM_BYTES = rv32x_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] instruction,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] executed_pc,
	output logic [31:0] next_pc,
	output logic        dest_write,
	output logic [4:0]  dest_index,
	output logic [31:0] dest_value,
	output logic [31:0] halt_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] start_pc
);

	// handshake and flow control
	logic in_acc;
	logic s1_adv;
	logic s2_adv;
	logic out_free;
	logic dm_busy;

	// state
	logic [31:0] pc_q;
	logic        halted_q;

	// stage 1
	logic        v_s1;
	logic [31:0] instr_s1;
	logic [4:0]  ra_s1;
	logic [4:0]  rb_s1;

	// stage 2
	logic                 v_s2;
	rv32x_pkg::status_t   st_s2;
	logic [31:0]          pc_s2;
	logic [31:0]          npc_s2;
	logic                 wr_s2;
	logic [4:0]           rd_s2;
	logic [31:0]          val_s2;
	logic                 lbu_s2;
	logic [31:0]          hc_s2;
	logic [31:0]          res_s2;

	// output register
	logic                 out_v_q;
	rv32x_pkg::status_t   status_q;
	logic [31:0]          epc_q;
	logic [31:0]          npc_q;
	logic                 dw_q;
	logic [4:0]           di_q;
	logic [31:0]          dv_q;
	logic [31:0]          hc_q;

	// last register write, for reads issued at the same edge
	logic        lw_v_q;
	logic [4:0]  lw_idx_q;
	logic [31:0] lw_data_q;

	// memory ports
	logic [4:0]          rf_ra;
	logic [31:0]         rf_a;
	logic [31:0]         rf_b;
	rv32x_pkg::rf_wr_t   rf_wr;
	rv32x_pkg::dm_req_t  dm_req;
	logic [7:0]          dm_byte;

	// execute logic
	rv32x_pkg::op_t      op;
	rv32x_pkg::status_t  st;
	logic [31:0] fa;
	logic [31:0] fb;
	logic [31:0] pc4;
	logic [31:0] immi;
	logic [31:0] imms;
	logic [31:0] immu;
	logic [31:0] immj;
	logic [31:0] sum_i;
	logic [31:0] sum_s;
	logic [31:0] npc;
	logic [31:0] val;
	logic [31:0] hc;
	logic        wr;
	logic        lbu;
	logic        halt_set;
	logic [3:0]  we;
	logic [4:0]  rd;

	// flow control
	assign out_free  = ~out_v_q | ~out_stall;
	assign s2_adv    = v_s2 & out_free;
	assign s1_adv    = v_s1 & (~v_s2 | out_free);
	assign in_stall  = dm_busy | (v_s1 & ~s1_adv);
	assign in_acc    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;

	// register reads; ebreak reads a0 on port a
	assign rf_ra = (instruction == rv32x_pkg::EBREAK_WORD) ? rv32x_pkg::REG_A0
		: instruction[19:15];

	rv32x_regfile u_rf (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.ra      (rf_ra),
		.rb      (instruction[24:20]),
		.rdata_a (rf_a),
		.rdata_b (rf_b),
		.wr      (rf_wr)
	);

	rv32x_dmem #(
		.MEM_BYTES (MEM_BYTES)
	) u_dm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dm_req),
		.rbyte  (dm_byte),
		.busy   (dm_busy)
	);

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc | (v_s1 & ~s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			instr_s1 <= instruction;
			ra_s1    <= rf_ra;
			rb_s1    <= instruction[24:20];
		end
	end

	// operand forwarding: stage 2 result, then last write, then register file
	assign res_s2 = lbu_s2 ? {24'b0, dm_byte} : val_s2;

	always_comb begin
		if (v_s2 && wr_s2 && rd_s2 == ra_s1) begin
			fa = res_s2;
		end else if (lw_v_q && lw_idx_q == ra_s1) begin
			fa = lw_data_q;
		end else begin
			fa = rf_a;
		end
		if (v_s2 && wr_s2 && rd_s2 == rb_s1) begin
			fb = res_s2;
		end else if (lw_v_q && lw_idx_q == rb_s1) begin
			fb = lw_data_q;
		end else begin
			fb = rf_b;
		end
	end

	// immediates and adders
	assign op    = rv32x_pkg::decode_op(instr_s1);
	assign rd    = instr_s1[11:7];
	assign pc4   = pc_q + 32'd4;
	assign immi  = {{20{instr_s1[31]}}, instr_s1[31:20]};
	assign imms  = {{20{instr_s1[31]}}, instr_s1[31:25], instr_s1[11:7]};
	assign immu  = {instr_s1[31:12], 12'b0};
	assign immj  = {{11{instr_s1[31]}}, instr_s1[31], instr_s1[19:12], instr_s1[20],
		instr_s1[30:21], 1'b0};
	assign sum_i = fa + immi;
	assign sum_s = fa + imms;

	// execute
	always_comb begin
		st       = rv32x_pkg::ST_EXEC;
		npc      = pc4;
		val      = '0;
		hc       = '0;
		wr       = 1'b0;
		lbu      = 1'b0;
		halt_set = 1'b0;
		we       = 4'b0000;
		if (halted_q) begin
			st  = rv32x_pkg::ST_IGNORED;
			npc = pc_q;
		end else begin
			unique case (op)
				rv32x_pkg::OP_AUIPC: begin
					val = pc_q + immu;
					wr  = (rd != 5'd0);
				end
				rv32x_pkg::OP_LBU: begin
					lbu = 1'b1;
					wr  = (rd != 5'd0);
				end
				rv32x_pkg::OP_SB: begin
					we = 4'b0001;
				end
				rv32x_pkg::OP_ADDI: begin
					val = sum_i;
					wr  = (rd != 5'd0);
				end
				rv32x_pkg::OP_JAL: begin
					val = pc4;
					wr  = (rd != 5'd0);
					npc = pc_q + immj;
				end
				rv32x_pkg::OP_JALR: begin
					val = pc4;
					wr  = (rd != 5'd0);
					npc = {sum_i[31:1], 1'b0};
				end
				rv32x_pkg::OP_SW: begin
					we = 4'b1111;
				end
				rv32x_pkg::OP_EBREAK: begin
					st       = rv32x_pkg::ST_EBREAK;
					hc       = fa;
					halt_set = 1'b1;
				end
				default: begin
					st       = rv32x_pkg::ST_INVALID;
					halt_set = 1'b1;
				end
			endcase
		end
	end

	// data memory access issued as the word leaves stage 1
	assign dm_req.rd_en = s1_adv & lbu;
	assign dm_req.we    = s1_adv ? we : 4'b0000;
	assign dm_req.addr  = (op == rv32x_pkg::OP_LBU) ? sum_i : sum_s;
	assign dm_req.wdata = fb;

	// program counter and halt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= rv32x_pkg::START_PC_RST;
			halted_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			pc_q <= start_pc;
		end else if (s1_adv) begin
			pc_q <= npc;
			if (halt_set) begin
				halted_q <= 1'b1;
			end
		end
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= s1_adv | (v_s2 & ~s2_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			st_s2  <= st;
			pc_s2  <= pc_q;
			npc_s2 <= npc;
			wr_s2  <= wr;
			rd_s2  <= wr ? rd : 5'd0;
			val_s2 <= val;
			lbu_s2 <= lbu;
			hc_s2  <= hc;
		end
	end

	// write back as the word enters the output register
	assign rf_wr.en   = s2_adv & wr_s2;
	assign rf_wr.idx  = rd_s2;
	assign rf_wr.data = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_v_q <= 1'b0;
		end else if (rf_wr.en) begin
			lw_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_wr.en) begin
			lw_idx_q  <= rf_wr.idx;
			lw_data_q <= rf_wr.data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= s2_adv | (out_v_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			status_q <= st_s2;
			epc_q    <= pc_s2;
			npc_q    <= npc_s2;
			dw_q     <= wr_s2;
			di_q     <= rd_s2;
			dv_q     <= wr_s2 ? res_s2 : '0;
			hc_q     <= hc_s2;
		end
	end

	assign out_valid   = out_v_q;
	assign status      = status_q;
	assign executed_pc = epc_q;
	assign next_pc     = npc_q;
	assign dest_write  = dw_q;
	assign dest_index  = di_q;
	assign dest_value  = dv_q;
	assign halt_code   = hc_q;

endmodule

### hw/rtl/rv32x_regfile.sv
// ----------------------------------------------------------------------------
// rv32x_regfile
// 32 x 32 register file: one write port, two registered read ports, and
// per-entry valid bits so that entries read as zero until first written.
// ----------------------------------------------------------------------------
module rv32x_regfile (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [4:0]          ra,
	input  logic [4:0]          rb,
	output logic [31:0]         rdata_a,
	output logic [31:0]         rdata_b,
	input  rv32x_pkg::rf_wr_t   wr
);

	logic [31:0] mem_q [32];
	logic [31:0] vld_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic        av_q;
	logic        bv_q;

	// storage and registered reads
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			a_q <= mem_q[ra];
			b_q <= mem_q[rb];
		end
	end

	// valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			av_q  <= 1'b0;
			bv_q  <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.idx] <= 1'b1;
			end
			if (rd_en) begin
				av_q <= vld_q[ra];
				bv_q <= vld_q[rb];
			end
		end
	end

	// never-written entries read zero
	assign rdata_a = av_q ? a_q : '0;
	assign rdata_b = bv_q ? b_q : '0;

endmodule

### hw/rtl/rv32x_dmem.sv
// ----------------------------------------------------------------------------
// rv32x_dmem
// Byte-addressed data memory built from four byte lanes with registered
// reads. Handles unaligned word stores across rows and clears itself one
// row per cycle after reset.
// ----------------------------------------------------------------------------
module rv32x_dmem #(
	parameter int unsigned MEM_BYTES = rv32x_pkg::MEM_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rv32x_pkg::dm_req_t  req,
	output logic [7:0]          rbyte,
	output logic                busy
);

	localparam int unsigned AW   = $clog2(MEM_BYTES);
	localparam int unsigned RW   = AW - 2;
	localparam int unsigned ROWS = MEM_BYTES / 4;

	logic [RW-1:0] clr_q;
	logic          clr_busy_q;
	logic [1:0]    sel_q;
	logic [7:0]    lane_rd [4];

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + RW'(1);
			if (clr_q == RW'(ROWS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// byte lanes
	for (genvar L = 0; L < 4; L++) begin : g_lane
		localparam logic [1:0] LN = 2'(L);
		logic [7:0]    mem_q [ROWS];
		logic [7:0]    rd_q;
		logic [1:0]    k;
		logic [RW-1:0] row;
		logic          we_l;
		logic [7:0]    wd;

		// byte k of the access lands in this lane, one row up when it wraps
		assign k    = LN - req.addr[1:0];
		assign row  = req.addr[AW-1:2] + {{(RW-1){1'b0}}, (LN < req.addr[1:0])};
		assign we_l = req.we[k];
		assign wd   = req.wdata[8*k +: 8];

		always_ff @(posedge clk) begin
			if (clr_busy_q) begin
				mem_q[clr_q] <= '0;
			end else if (we_l) begin
				mem_q[row] <= wd;
			end
			if (req.rd_en) begin
				rd_q <= mem_q[row];
			end
		end

		assign lane_rd[L] = rd_q;
	end

	// lane of the byte being loaded
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			sel_q <= req.addr[1:0];
		end
	end

	assign rbyte = lane_rd[sel_q];
	assign busy  = clr_busy_q;

endmodule

### hw/rtl/rv32x_checker.sv
// ----------------------------------------------------------------------------
// rv32x_checker
// Port-level checks on the result words of the rv32i subset execute block.
// ----------------------------------------------------------------------------
module rv32x_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [31:0] instruction,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] executed_pc,
	input logic [31:0] next_pc,
	input logic        dest_write,
	input logic [4:0]  dest_index,
	input logic [31:0] dest_value,
	input logic [31:0] halt_code,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [31:0] start_pc
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(next_pc)
			&& $stable(dest_value))
		else $error("result word changed while stalled");

	// no destination means all destination fields are zero
	a_no_dest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dest_write |-> dest_index == 5'd0 && dest_value == 32'd0)
		else $error("destination fields set without a write");

	// x0 is never reported as written
	a_x0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dest_write |-> dest_index != 5'd0)
		else $error("write to x0 reported");

	// an ignored word changes nothing
	a_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rv32x_pkg::ST_IGNORED |->
			!dest_write && halt_code == 32'd0 && next_pc == executed_pc)
		else $error("ignored word has side effects");

	// an invalid halt steps past the word with no halt code
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == rv32x_pkg::ST_INVALID |->
			!dest_write && halt_code == 32'd0 && next_pc == executed_pc + 32'd4)
		else $error("invalid halt result malformed");

endmodule

bind rv32i_subset_execute rv32x_checker u_chk (.*);

### test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rv32i subset execute testbench
// Drives instruction words into the execute block and tracks the register
// file, program counter and data memory on the side. Each result word is
// compared field by field against the oldest predicted one. A directed run
// goes first, then random programs under several start addresses, then a
// halt followed by ignored words.
// ----------------------------------------------------------------------------
package exec_check_pkg;
	import rv32x_pkg::*;

	localparam int unsigned DMEM_BYTES = MEM_BYTES_DEF;

	// major opcodes and function codes of the supported subset
	localparam logic [6:0] OPC_AUIPC = 7'b0010111;
	localparam logic [6:0] OPC_LOAD  = 7'b0000011;
	localparam logic [6:0] OPC_STORE = 7'b0100011;
	localparam logic [6:0] OPC_OPIMM = 7'b0010011;
	localparam logic [6:0] OPC_JAL   = 7'b1101111;
	localparam logic [6:0] OPC_JALR  = 7'b1100111;
	localparam logic [2:0] F3_LBU    = 3'd4;
	localparam logic [2:0] F3_SB     = 3'd0;
	localparam logic [2:0] F3_SW     = 3'd2;
	localparam logic [2:0] F3_ADDI   = 3'd0;
	localparam logic [2:0] F3_JALR   = 3'd0;

	typedef struct packed {
		status_t     status;
		logic [31:0] executed_pc;
		logic [31:0] next_pc;
		logic        dest_write;
		logic [4:0]  dest_index;
		logic [31:0] dest_value;
		logic [31:0] halt_code;
	} exec_result_t;

	// sort a word into one of the supported operations
	function automatic op_t classify(logic [31:0] w);
		logic [2:0] f3;
		f3 = w[14:12];
		case (w[6:0])
			OPC_AUIPC: return OP_AUIPC;
			OPC_LOAD:  return (f3 == F3_LBU) ? OP_LBU : OP_INVALID;
			OPC_STORE: return (f3 == F3_SB) ? OP_SB : (f3 == F3_SW) ? OP_SW : OP_INVALID;
			OPC_OPIMM: return (f3 == F3_ADDI) ? OP_ADDI : OP_INVALID;
			OPC_JAL:   return OP_JAL;
			OPC_JALR:  return (f3 == F3_JALR) ? OP_JALR : OP_INVALID;
			default:   return (w == EBREAK_WORD) ? OP_EBREAK : OP_INVALID;
		endcase
	endfunction

	// assemble one instruction; imm is the full offset (upper bits for auipc)
	function automatic logic [31:0] encode(op_t op, logic [4:0] rd, logic [4:0] rs1,
			logic [4:0] rs2, logic [31:0] imm);
		case (op)
			OP_AUIPC:  return {imm[31:12], rd, OPC_AUIPC};
			OP_LBU:    return {imm[11:0], rs1, F3_LBU, rd, OPC_LOAD};
			OP_SB:     return {imm[11:5], rs2, rs1, F3_SB, imm[4:0], OPC_STORE};
			OP_ADDI:   return {imm[11:0], rs1, F3_ADDI, rd, OPC_OPIMM};
			OP_JAL:    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
			OP_JALR:   return {imm[11:0], rs1, F3_JALR, rd, OPC_JALR};
			OP_SW:     return {imm[11:5], rs2, rs1, F3_SW, imm[4:0], OPC_STORE};
			OP_EBREAK: return EBREAK_WORD;
			default:   return 32'h0000_0000;
		endcase
	endfunction

	// architectural shadow of the block plus the words it still owes
	class exec_tracker;
		logic [31:0] gpr [32];
		logic [7:0]  dmem [DMEM_BYTES];
		logic [31:0] boot_pc;
		logic [31:0] pc;
		bit          halted;
		exec_result_t due_results [$];
		int          mismatches;

		function new();
			boot_pc = START_PC_RST;
			pc = boot_pc;
			halted = 1'b0;
			mismatches = 0;
			foreach (gpr[i]) gpr[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
		endfunction

		function void load_start_pc(logic [31:0] v);
			boot_pc = v;
			pc = v;
		endfunction

		function bit all_retired();
			return due_results.size() == 0;
		endfunction

		function int unsigned slot(logic [31:0] addr);
			return addr % DMEM_BYTES;
		endfunction

		// x0 is never written and reports no destination
		function void put_reg(inout exec_result_t r, input logic [4:0] rd,
				input logic [31:0] v);
			if (rd != '0) begin
				gpr[rd] = v;
				r.dest_write = 1'b1;
				r.dest_index = rd;
				r.dest_value = v;
			end
		endfunction

		// execute one accepted word and queue the result it must produce
		function void note_word(logic [31:0] w);
			exec_result_t r;
			logic [31:0] a, b, imm_i, imm_s, imm_j, nxt, base;
			logic [4:0] rd;
			r = '0;
			r.executed_pc = pc;
			if (halted) begin
				r.status = ST_IGNORED;
				r.next_pc = pc;
				due_results.push_back(r);
				return;
			end
			rd = w[11:7];
			a = gpr[w[19:15]];
			b = gpr[w[24:20]];
			imm_i = {{20{w[31]}}, w[31:20]};
			imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
			imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
			nxt = pc + 32'd4;
			r.status = ST_EXEC;
			case (classify(w))
				OP_AUIPC: put_reg(r, rd, pc + {w[31:12], 12'b0});
				OP_LBU:   put_reg(r, rd, {24'b0, dmem[slot(a + imm_i)]});
				OP_SB:    dmem[slot(a + imm_s)] = b[7:0];
				OP_ADDI:  put_reg(r, rd, a + imm_i);
				OP_JAL: begin
					put_reg(r, rd, pc + 32'd4);
					nxt = pc + imm_j;
				end
				OP_JALR: begin
					// target comes from the old rs1 even when rd is the same register
					nxt = (a + imm_i) & ~32'd1;
					put_reg(r, rd, pc + 32'd4);
				end
				OP_SW: begin
					base = a + imm_s;
					// little-endian, each byte address wraps on its own
					for (int k = 0; k < 4; k++)
						dmem[slot(base + 32'(k))] = b[8*k +: 8];
				end
				OP_EBREAK: begin
					r.status = ST_EBREAK;
					r.halt_code = gpr[REG_A0];
					halted = 1'b1;
				end
				default: begin
					r.status = ST_INVALID;
					halted = 1'b1;
				end
			endcase
			pc = nxt;
			r.next_pc = nxt;
			due_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
			if (seen !== want) begin
				$error("%s: expected 0x%08h, actual 0x%08h", name, want, seen);
				mismatches++;
			end
		endfunction

		// compare one result word against the oldest prediction
		function void check_word(exec_result_t got);
			exec_result_t want;
			if (due_results.size() == 0) begin
				$error("result word at pc 0x%08h with nothing expected", got.executed_pc);
				mismatches++;
				return;
			end
			want = due_results.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("executed_pc", want.executed_pc, got.executed_pc);
			compare_field("next_pc", want.next_pc, got.next_pc);
			compare_field("dest_write", 32'(want.dest_write), 32'(got.dest_write));
			compare_field("dest_index", 32'(want.dest_index), 32'(got.dest_index));
			compare_field("dest_value", want.dest_value, got.dest_value);
			compare_field("halt_code", want.halt_code, got.halt_code);
		endfunction
	endclass
endpackage

module tb;
	import rv32x_pkg::*;
	import exec_check_pkg::*;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] instruction = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] executed_pc;
	logic [31:0] next_pc;
	logic        dest_write;
	logic [4:0]  dest_index;
	logic [31:0] dest_value;
	logic [31:0] halt_code;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] start_pc = '0;

	exec_tracker  trk = new;
	bit           calm = 1'b0;
	int           rx_hold = 0;
	exec_result_t seen;

	rv32i_subset_execute dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.instruction(instruction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.executed_pc(executed_pc),
		.next_pc(next_pc),
		.dest_write(dest_write),
		.dest_index(dest_index),
		.dest_value(dest_value),
		.halt_code(halt_code),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.start_pc(start_pc)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// alternate stretches of random idling with stretches of none
	initial begin
		forever begin
			repeat ($urandom_range(40, 200)) @(posedge clk);
			calm = ~calm;
		end
	end

	function automatic int pick_wait();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	// random well-formed instruction of the subset
	function automatic logic [31:0] random_word();
		op_t op;
		logic [4:0] rd, rs1, rs2;
		logic [31:0] imm;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) op = OP_ADDI;
		else if (pick < 40) op = OP_LBU;
		else if (pick < 52) op = OP_SB;
		else if (pick < 64) op = OP_SW;
		else if (pick < 76) op = OP_AUIPC;
		else if (pick < 88) op = OP_JAL;
		else op = OP_JALR;
		rd = 5'($urandom_range(0, 31));
		rs2 = 5'($urandom_range(0, 31));
		// half use a few base registers and short offsets so loads hit stores
		if ($urandom_range(0, 1) == 1) begin
			rs1 = 5'($urandom_range(0, 3));
			imm = 32'($urandom_range(0, 31)) - 32'd16;
		end else begin
			rs1 = 5'($urandom_range(0, 31));
			imm = $urandom();
		end
		return encode(op, rd, rs1, rs2, imm);
	endfunction

	// present one word after a random gap and wait until it is taken
	task automatic send_word(input logic [31:0] w);
		int gap;
		gap = pick_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		instruction <= w;
		do @(posedge clk); while (in_stall);
		trk.note_word(w);
	endtask

	// let every owed result come back before going on
	task automatic drain();
		in_valid <= 1'b0;
		while (!trk.all_retired()) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_start_pc(input logic [31:0] v);
		cfg_valid <= 1'b1;
		start_pc <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		trk.load_start_pc(v);
	endtask

	// result side: check each taken word, then stall the output or not at random
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			seen.status = status_t'(status);
			seen.executed_pc = executed_pc;
			seen.next_pc = next_pc;
			seen.dest_write = dest_write;
			seen.dest_index = dest_index;
			seen.dest_value = dest_value;
			seen.halt_code = halt_code;
			trk.check_word(seen);
			rx_hold = pick_wait();
		end
		if (rx_hold > 0) begin
			out_stall <= 1'b1;
			rx_hold--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// run limit
	initial begin
		#1_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [31:0] w, v;
		logic [6:0] opc;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		drain();

		// directed: reset start address, immediate extremes, x0 targets, wrapping
		send_word(encode(OP_ADDI, 5'd1, 5'd0, 5'd0, 32'd2047));
		send_word(encode(OP_ADDI, 5'd2, 5'd0, 5'd0, 32'hFFFF_F800));
		send_word(encode(OP_ADDI, 5'd0, 5'd1, 5'd0, 32'd5));
		send_word(encode(OP_ADDI, 5'd31, 5'd2, 5'd0, 32'hFFFF_FFFF));
		send_word(encode(OP_AUIPC, 5'd3, 5'd0, 5'd0, 32'hFFFF_F000));
		send_word(encode(OP_AUIPC, 5'd0, 5'd0, 5'd0, 32'h1234_5000));
		send_word(encode(OP_SW, 5'd0, 5'd0, 5'd31, 32'd0));
		send_word(encode(OP_LBU, 5'd4, 5'd0, 5'd0, 32'd0));
		send_word(encode(OP_LBU, 5'd5, 5'd0, 5'd0, 32'd3));
		send_word(encode(OP_SB, 5'd0, 5'd0, 5'd1, 32'd2));
		send_word(encode(OP_LBU, 5'd6, 5'd0, 5'd0, 32'd2));
		send_word(encode(OP_ADDI, 5'd8, 5'd0, 5'd0, 32'hFFFF_FFFF));
		// store word straddling the top of the address space
		send_word(encode(OP_SW, 5'd0, 5'd8, 5'd2, 32'hFFFF_FFFF));
		send_word(encode(OP_LBU, 5'd7, 5'd8, 5'd0, 32'hFFFF_FFFF));
		send_word(encode(OP_LBU, 5'd9, 5'd0, 5'd0, 32'd1));
		send_word(encode(OP_SW, 5'd0, 5'd0, 5'd1, 32'd1));
		send_word(encode(OP_LBU, 5'd11, 5'd0, 5'd0, 32'd1));
		send_word(encode(OP_LBU, 5'd0, 5'd0, 5'd0, 32'd2));
		send_word(encode(OP_JAL, 5'd10, 5'd0, 5'd0, 32'hFFFF_FFFC));
		send_word(encode(OP_JAL, 5'd0, 5'd0, 5'd0, 32'h000F_FFFE));
		send_word(encode(OP_JALR, 5'd12, 5'd8, 5'd0, 32'd1));
		send_word(encode(OP_JALR, 5'd0, 5'd0, 5'd0, 32'd3));
		send_word(encode(OP_JALR, 5'd13, 5'd31, 5'd0, 32'hFFFF_F800));
		send_word(encode(OP_JALR, 5'd1, 5'd1, 5'd0, 32'd0));

		// random programs under several start addresses
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			case (ph)
				0: v = 32'h0000_0000;
				1: v = 32'hFFFF_FFFF;
				2: v = 32'hFFFF_FFFC;
				default: v = $urandom();
			endcase
			write_start_pc(v);
			repeat (80) send_word(random_word());
		end

		// halt by ebreak or by some invalid encoding
		drain();
		write_start_pc($urandom());
		repeat (5) send_word(random_word());
		send_word(encode(OP_ADDI, REG_A0, 5'd0, 5'd0, 32'($urandom_range(1, 2047))));
		case ($urandom_range(0, 4))
			0, 1: w = EBREAK_WORD;
			2: w = EBREAK_WORD ^ (32'd1 << $urandom_range(0, 31));
			3: begin
				case ($urandom_range(0, 3))
					0: opc = OPC_LOAD;
					1: opc = OPC_STORE;
					2: opc = OPC_OPIMM;
					default: opc = OPC_JALR;
				endcase
				do begin
					w = $urandom();
					w[6:0] = opc;
				end while (classify(w) != OP_INVALID);
			end
			default: begin
				do w = $urandom(); while (classify(w) != OP_INVALID);
			end
		endcase
		send_word(w);

		// everything after the halt is ignored; a new start address still moves the pc they report
		repeat (20) send_word($urandom());
		send_word(EBREAK_WORD);
		drain();
		write_start_pc($urandom());
		repeat (10) send_word($urandom());

		drain();
		if (trk.mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
